@@ rtl/core/cbtm_pkg.sv @@
`timescale 1ns / 1ps

package cbtm_pkg;

    // Default widths of the DAC code and of the UI level.
    localparam int RAW_BITS_DEF = 12;
    localparam int UI_BITS_DEF  = 7;

    // Reset value of the number of UI steps at full scale.
    localparam int UI_MAX_RESET = 100;

    // Register file: byte address bits and register indexes.
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RAW_MIN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RAW_MAX = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_UI_MAX  = 2'd2;

    // Command codes.
    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    // Control into the shared divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status out of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/core/cbtm_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient must fit Q_W bits.
module cbtm_div #(
    parameter int DIV_W = 41,
    parameter int DEN_W = 21,
    parameter int Q_W   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cbtm_pkg::t_div_ctl     i_ctl,
    input  logic [DIV_W-1:0]       i_dividend,
    input  logic [DEN_W-1:0]       i_divisor,
    output logic [Q_W-1:0]         o_quotient,
    output cbtm_pkg::t_div_stat    o_stat
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] n_den;
    logic [Q_W-1:0]   r_quot;
    logic [Q_W-1:0]   n_quot;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic             w_ge;

    assign w_ge = (r_rem >= r_den);

    // One compare and subtract per cycle against the shifted divisor.
    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_rem  = i_dividend;
            n_den  = DIV_W'(i_divisor) << (Q_W - 1);
            n_quot = '0;
            n_cnt  = CNT_W'(Q_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_ge) begin
                n_rem = r_rem - r_den;
            end
            n_quot = {r_quot[Q_W-2:0], w_ge};
            n_den  = r_den >> 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_quotient  = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ rtl/core/cubic_brightness_taper_map_core.sv @@
`timescale 1ns / 1ps

// Cubic brightness taper: maps a UI level to a DAC code, or a DAC code to the
// nearest UI level. One input word (command, level, code) is taken on the
// i_in_valid / o_in_ready handshake and gives one output word on o_out_valid /
// i_out_ready; the field of the command not used reads as zero.
// The three registers (raw minimum, raw maximum, UI steps) sit on the APB port
// at byte addresses 0, 4 and 8; the user must write them only while the block
// is idle, since the block itself does not enforce it. Each taper step is one
// multiply, one divider pass and the update. A forward word walks the taper
// step by step to the requested level; a level at or above full scale skips
// the walk. An inverse word runs the taper once per binary search probe (up to
// ceil(log2(steps + 1)) probes) and once more to the final level. One word is
// worked on at a time; o_in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled receiver does not stop
// the next word from being taken; it only holds the sequencer at its end.
// Synchronous reset returns the registers to 0, all ones and 100 and drops
// o_out_valid.
module cubic_brightness_taper_map_core #(
    parameter int RAW_BITS = cbtm_pkg::RAW_BITS_DEF,
    parameter int UI_BITS  = cbtm_pkg::UI_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB-style register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbtm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [UI_BITS-1:0]           i_ui_level_in,
    input  logic [RAW_BITS-1:0]          i_raw_code_in,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [RAW_BITS-1:0]          o_raw_code_out,
    output logic [UI_BITS-1:0]           o_ui_level_out
);

    localparam int CUBE_W = 3 * UI_BITS;
    localparam int SQ_W   = 2 * UI_BITS;
    localparam int NUM_W  = CUBE_W + RAW_BITS;
    localparam int DIV_W  = NUM_W + 1;
    localparam int RAW_W1 = RAW_BITS + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEN1  = 10'b0000000010,
        S_DEN2  = 10'b0000000100,
        S_SRCH  = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_DIVGO = 10'b0001000000,
        S_DIVW  = 10'b0010000000,
        S_DEC   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    // What the taper walk is computing for.
    typedef enum logic [3:0] {
        P_FWD    = 4'b0001,
        P_SEARCH = 4'b0010,
        P_PREV   = 4'b0100,
        P_CAND   = 4'b1000
    } t_phase;

    // Configuration registers.
    logic [RAW_BITS-1:0] r_raw_min;
    logic [RAW_BITS-1:0] r_raw_max;
    logic [UI_BITS-1:0]  r_ui_max;

    // Sequencer and datapath registers.
    t_state              r_state;
    t_state              n_state;
    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_cmd;
    logic                n_cmd;
    logic [UI_BITS-1:0]  r_level;
    logic [UI_BITS-1:0]  n_level;
    logic [RAW_BITS-1:0] r_code;
    logic [RAW_BITS-1:0] n_code;
    logic [CUBE_W-1:0]   r_denom;
    logic [CUBE_W-1:0]   n_denom;
    logic [NUM_W-1:0]    r_prod;
    logic [NUM_W-1:0]    n_prod;
    logic [UI_BITS-1:0]  r_s;
    logic [UI_BITS-1:0]  n_s;
    logic [UI_BITS-1:0]  r_target;
    logic [UI_BITS-1:0]  n_target;
    logic [SQ_W-1:0]     r_sq;
    logic [SQ_W-1:0]     n_sq;
    logic [CUBE_W-1:0]   r_cube;
    logic [CUBE_W-1:0]   n_cube;
    logic [RAW_BITS-1:0] r_cur;
    logic [RAW_BITS-1:0] n_cur;
    logic [RAW_BITS-1:0] r_prev;
    logic [RAW_BITS-1:0] n_prev;
    logic [RAW_BITS-1:0] r_cand;
    logic [RAW_BITS-1:0] n_cand;
    logic [UI_BITS-1:0]  r_lo;
    logic [UI_BITS-1:0]  n_lo;
    logic [UI_BITS-1:0]  r_hi;
    logic [UI_BITS-1:0]  n_hi;
    logic [RAW_BITS-1:0] r_res_raw;
    logic [RAW_BITS-1:0] n_res_raw;
    logic [UI_BITS-1:0]  r_res_ui;
    logic [UI_BITS-1:0]  n_res_ui;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [RAW_BITS-1:0] r_out_raw;
    logic [RAW_BITS-1:0] n_out_raw;
    logic [UI_BITS-1:0]  r_out_ui;
    logic [UI_BITS-1:0]  n_out_ui;

    // Combinational helpers.
    localparam int REG_IDX_SEL_W = cbtm_pkg::REG_IDX_W;
    logic [REG_IDX_SEL_W-1:0] w_reg_idx;
    logic                w_cfg_wr;
    logic [RAW_BITS-1:0] w_span;
    logic [CUBE_W-1:0]   w_mul_a;
    logic [RAW_BITS-1:0] w_mul_b;
    logic [NUM_W-1:0]    w_mul_p;
    logic [DIV_W-1:0]    w_dividend;
    logic [RAW_BITS-1:0] w_quot;
    logic [RAW_W1-1:0]   w_ideal;
    logic [RAW_W1-1:0]   w_bumped;
    logic [RAW_BITS-1:0] w_next_cur;
    logic [UI_BITS-1:0]  w_mid;
    logic [RAW_BITS-1:0] w_up;
    logic [RAW_BITS-1:0] w_dn;
    logic                w_fin_go;
    cbtm_pkg::t_div_ctl  w_div_ctl;
    cbtm_pkg::t_div_stat w_div_stat;

    // Register port.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[cbtm_pkg::PADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_comb begin
        unique case (w_reg_idx)
            cbtm_pkg::REG_RAW_MIN: prdata = 32'(r_raw_min);
            cbtm_pkg::REG_RAW_MAX: prdata = 32'(r_raw_max);
            cbtm_pkg::REG_UI_MAX:  prdata = 32'(r_ui_max);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_min <= '0;
            r_raw_max <= '1;
            r_ui_max  <= UI_BITS'(cbtm_pkg::UI_MAX_RESET);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                cbtm_pkg::REG_RAW_MIN: r_raw_min <= pwdata[RAW_BITS-1:0];
                cbtm_pkg::REG_RAW_MAX: r_raw_max <= pwdata[RAW_BITS-1:0];
                cbtm_pkg::REG_UI_MAX:  r_ui_max  <= pwdata[UI_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Span of the taper; zero when the ends are not in order.
    assign w_span = (r_raw_max > r_raw_min) ? (r_raw_max - r_raw_min) : '0;

    // Shared multiplier: the cube of full scale at the start, then s^3 * span.
    always_comb begin
        unique case (r_state)
            S_DEN1: begin
                w_mul_a = CUBE_W'(r_ui_max);
                w_mul_b = RAW_BITS'(r_ui_max);
            end
            S_DEN2: begin
                w_mul_a = r_prod[CUBE_W-1:0];
                w_mul_b = RAW_BITS'(r_ui_max);
            end
            default: begin
                w_mul_a = r_cube;
                w_mul_b = w_span;
            end
        endcase
    end
    assign w_mul_p = NUM_W'(w_mul_a) * NUM_W'(w_mul_b);

    // Rounded division s^3 * span / full^3 in the shared divider.
    assign w_dividend      = DIV_W'(r_prod) + DIV_W'(r_denom >> 1);
    assign w_div_ctl.start = (r_state == S_DIVGO);

    cbtm_div #(
        .DIV_W (DIV_W),
        .DEN_W (CUBE_W),
        .Q_W   (RAW_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (r_denom),
        .o_quotient (w_quot),
        .o_stat     (w_div_stat)
    );

    // Next taper value: strictly above the last one, capped at the maximum.
    always_comb begin
        w_ideal = RAW_W1'(r_raw_min) + RAW_W1'(w_quot);
        if (w_ideal <= RAW_W1'(r_cur)) begin
            w_bumped = RAW_W1'(r_cur) + 1'b1;
        end else begin
            w_bumped = w_ideal;
        end
        if (w_bumped > RAW_W1'(r_raw_max)) begin
            w_next_cur = r_raw_max;
        end else begin
            w_next_cur = w_bumped[RAW_BITS-1:0];
        end
    end

    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_up     = r_cand - r_code;
    assign w_dn     = r_code - r_prev;
    assign w_fin_go = !r_out_valid || i_out_ready;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_level     = r_level;
        n_code      = r_code;
        n_denom     = r_denom;
        n_prod      = r_prod;
        n_s         = r_s;
        n_target    = r_target;
        n_sq        = r_sq;
        n_cube      = r_cube;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_cand      = r_cand;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res_raw   = r_res_raw;
        n_res_ui    = r_res_ui;
        n_out_raw   = r_out_raw;
        n_out_ui    = r_out_ui;
        n_out_valid = r_out_valid;

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_level = i_ui_level_in;
                    n_code  = i_raw_code_in;
                    n_state = S_DEN1;
                end
            end
            S_DEN1: begin
                n_prod  = w_mul_p;
                n_state = S_DEN2;
            end
            S_DEN2: begin
                n_denom   = w_mul_p[CUBE_W-1:0];
                n_res_raw = '0;
                n_res_ui  = '0;
                if (r_cmd == cbtm_pkg::CMD_FORWARD) begin
                    if (r_level >= r_ui_max) begin
                        n_res_raw = r_raw_max;
                        n_state   = S_FIN;
                    end else begin
                        n_cur    = r_raw_min;
                        n_s      = '0;
                        n_sq     = '0;
                        n_cube   = '0;
                        n_target = r_level;
                        n_phase  = P_FWD;
                        n_state  = S_CHK;
                    end
                end else begin
                    // Clamp at both ends, the lower end first.
                    if (r_code <= r_raw_min) begin
                        n_state = S_FIN;
                    end else if (r_code >= r_raw_max) begin
                        n_res_ui = r_ui_max;
                        n_state  = S_FIN;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_ui_max;
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_cur    = r_raw_min;
                    n_s      = '0;
                    n_sq     = '0;
                    n_cube   = '0;
                    n_target = w_mid;
                    n_phase  = P_SEARCH;
                    n_state  = S_CHK;
                end else if (r_lo == '0) begin
                    n_state = S_FIN;
                end else begin
                    // Walk to the level below; the candidate is one step on.
                    n_cur    = r_raw_min;
                    n_s      = '0;
                    n_sq     = '0;
                    n_cube   = '0;
                    n_target = r_lo - 1'b1;
                    n_phase  = P_PREV;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (r_s == r_target) begin
                    unique case (r_phase)
                        P_FWD: begin
                            n_res_raw = r_cur;
                            n_state   = S_FIN;
                        end
                        P_SEARCH: begin
                            if (r_cur < r_code) begin
                                n_lo = r_target + 1'b1;
                            end else begin
                                n_hi = r_target;
                            end
                            n_state = S_SRCH;
                        end
                        P_PREV: begin
                            n_prev = r_cur;
                            if (r_lo >= r_ui_max) begin
                                n_cand  = r_raw_max;
                                n_state = S_DEC;
                            end else begin
                                n_target = r_lo;
                                n_phase  = P_CAND;
                            end
                        end
                        P_CAND: begin
                            n_cand  = r_cur;
                            n_state = S_DEC;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    // Step on: keep s^2 and s^3 by differences.
                    n_s     = r_s + 1'b1;
                    n_sq    = r_sq + (SQ_W'(r_s) << 1) + 1'b1;
                    n_cube  = r_cube + (CUBE_W'(r_sq) << 1) + CUBE_W'(r_sq)
                            + (CUBE_W'(r_s) << 1) + CUBE_W'(r_s) + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = w_mul_p;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (w_div_stat.done) begin
                    n_cur   = w_next_cur;
                    n_state = S_CHK;
                end
            end
            S_DEC: begin
                // Nearer neighbor; a tie goes to the lower level.
                if (w_up < w_dn) begin
                    n_res_ui = r_lo;
                end else begin
                    n_res_ui = r_lo - 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_out_raw   = r_res_raw;
                    n_out_ui    = r_res_ui;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_cmd     <= n_cmd;
        r_level   <= n_level;
        r_code    <= n_code;
        r_denom   <= n_denom;
        r_prod    <= n_prod;
        r_s       <= n_s;
        r_target  <= n_target;
        r_sq      <= n_sq;
        r_cube    <= n_cube;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_cand    <= n_cand;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_res_raw <= n_res_raw;
        r_res_ui  <= n_res_ui;
        r_out_raw <= n_out_raw;
        r_out_ui  <= n_out_ui;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_raw_code_out = r_out_raw;
    assign o_ui_level_out = r_out_ui;

endmodule

@@ verif/cubic_brightness_taper_map_core_tb.sv @@
`timescale 1ns / 1ps

module cubic_brightness_taper_map_core_tb;

    localparam int RAW_W = cbtm_pkg::RAW_BITS_DEF;
    localparam int UI_W  = cbtm_pkg::UI_BITS_DEF;

    typedef struct {
        logic [RAW_W-1:0] raw_code;
        logic [UI_W-1:0]  ui_level;
    } t_taper_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [cbtm_pkg::PADDR_W-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_command;
    logic [UI_W-1:0]     i_ui_level_in;
    logic [RAW_W-1:0]    i_raw_code_in;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [RAW_W-1:0]    o_raw_code_out;
    logic [UI_W-1:0]     o_ui_level_out;

    // Local copy of the taper registers, updated on every register write.
    logic [RAW_W-1:0]    cfg_raw_min;
    logic [RAW_W-1:0]    cfg_raw_max;
    logic [UI_W-1:0]     cfg_ui_max;

    t_taper_result       pending_results[$];
    int                  fail_count   = 0;
    bit                  gaps_on      = 1'b1;
    int                  hold_request = 0;

    cubic_brightness_taper_map_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_ui_level_in  (i_ui_level_in),
        .i_raw_code_in  (i_raw_code_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_raw_code_out (o_raw_code_out),
        .o_ui_level_out (o_ui_level_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Forward taper: DAC code for a UI level under the current registers.
    function automatic logic [RAW_W-1:0] taper_code(input int unsigned level);
        longint unsigned lo_code;
        longint unsigned hi_code;
        longint unsigned steps;
        longint unsigned span;
        longint unsigned denom;
        longint unsigned ideal;
        longint unsigned cur;
        longint unsigned s;
        lo_code = cfg_raw_min;
        hi_code = cfg_raw_max;
        steps   = cfg_ui_max;
        if (level >= steps) begin
            return cfg_raw_max;
        end
        span  = (hi_code > lo_code) ? (hi_code - lo_code) : 0;
        denom = steps * steps * steps;
        cur   = lo_code;
        for (s = 1; s <= level; s++) begin
            ideal = lo_code + (s * s * s * span + denom / 2) / denom;
            // Each step must climb by at least one code, but never past the top.
            if (ideal <= cur) begin
                ideal = cur + 1;
            end
            if (ideal > hi_code) begin
                ideal = hi_code;
            end
            cur = ideal;
        end
        return RAW_W'(cur);
    endfunction

    // Inverse taper: nearest UI level for a DAC code, ties to the lower level.
    function automatic logic [UI_W-1:0] nearest_level(input int unsigned code);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned above;
        int unsigned below;
        if (code <= cfg_raw_min) begin
            return '0;
        end
        if (code >= cfg_raw_max) begin
            return cfg_ui_max;
        end
        lo = 0;
        hi = cfg_ui_max;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (taper_code(mid) < code) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (lo == 0) begin
            return '0;
        end
        above = taper_code(lo);
        below = taper_code(lo - 1);
        return ((above - code) < (code - below)) ? UI_W'(lo) : UI_W'(lo - 1);
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    // Receiver stall length once a stall has been decided.
    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 4);
        end else if (r < 97) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(100, 300);
    endfunction

    // One APB write: setup, access, then idle.
    task automatic write_register(input logic [cbtm_pkg::REG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cbtm_pkg::REG_RAW_MIN: cfg_raw_min = value[RAW_W-1:0];
            cbtm_pkg::REG_RAW_MAX: cfg_raw_max = value[RAW_W-1:0];
            cbtm_pkg::REG_UI_MAX:  cfg_ui_max  = value[UI_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Send one word and record its predicted result once it is taken.
    task automatic send_word(input logic cmd, input int unsigned level, input int unsigned code);
        int gap;
        t_taper_result predicted;
        gap = send_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_ui_level_in <= UI_W'(level);
        i_raw_code_in <= RAW_W'(code);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == cbtm_pkg::CMD_INVERSE) begin
            predicted.raw_code = '0;
            predicted.ui_level = nearest_level(code & ((1 << RAW_W) - 1));
        end else begin
            predicted.raw_code = taper_code(level & ((1 << UI_W) - 1));
            predicted.ui_level = '0;
        end
        pending_results.push_back(predicted);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Program all three taper registers with the block idle.
    task automatic set_taper(input int unsigned lo_code, input int unsigned hi_code,
                             input int unsigned steps);
        wait_for_results();
        write_register(cbtm_pkg::REG_RAW_MIN, lo_code);
        write_register(cbtm_pkg::REG_RAW_MAX, hi_code);
        write_register(cbtm_pkg::REG_UI_MAX, steps);
    endtask

    // A random word, mostly inside the configured ranges.
    task automatic send_random_word();
        logic cmd;
        int unsigned level;
        int unsigned code;
        cmd = $urandom_range(0, 1) ? cbtm_pkg::CMD_INVERSE : cbtm_pkg::CMD_FORWARD;
        if ($urandom_range(0, 99) < 80) begin
            level = $urandom_range(0, cfg_ui_max);
        end else begin
            level = $urandom_range(0, (1 << UI_W) - 1);
        end
        if ($urandom_range(0, 99) < 80 && cfg_raw_min < cfg_raw_max) begin
            code = $urandom_range(cfg_raw_min, cfg_raw_max);
        end else begin
            code = $urandom_range(0, (1 << RAW_W) - 1);
        end
        send_word(cmd, level, code);
    endtask

    // Reset registers: ends of both ranges, midpoints and a level past full scale.
    task automatic test_default_taper();
        send_word(cbtm_pkg::CMD_FORWARD, 0, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 1, 4095);
        send_word(cbtm_pkg::CMD_FORWARD, 50, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 99, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 100, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 127, 4095);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 0);
        send_word(cbtm_pkg::CMD_INVERSE, 127, 1);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 2048);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 4094);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 4095);
    endtask

    // Minimum above maximum, zero steps, and more than 100 steps.
    task automatic test_degenerate_settings();
        set_taper(3000, 1000, 10);
        send_word(cbtm_pkg::CMD_FORWARD, 0, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 7, 0);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 3000);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 3001);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 500);
        set_taper(0, 4095, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 0, 0);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 2000);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 4095);
        set_taper(5, 4090, 127);
        send_word(cbtm_pkg::CMD_FORWARD, 126, 0);
        send_word(cbtm_pkg::CMD_FORWARD, 127, 0);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 1234);
        send_word(cbtm_pkg::CMD_INVERSE, 0, 4089);
    endtask

    // Receiver holds off long enough that the block fills and stops taking words.
    task automatic test_backpressure();
        set_taper(100, 3900, 20);
        gaps_on      = 1'b0;
        hold_request = 3000;
        for (int i = 0; i < 10; i++) begin
            send_word(cbtm_pkg::CMD_FORWARD, $urandom_range(0, 8), 0);
        end
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // Random words under a series of register settings, extremes included.
    task automatic test_random_settings();
        int unsigned lo_code;
        int unsigned hi_code;
        int unsigned steps;
        int words;
        for (int phase = 0; phase < 6; phase++) begin
            words = 20;
            lo_code = $urandom_range(0, 2000);
            hi_code = $urandom_range(lo_code + 1, 4095);
            steps   = $urandom_range(1, 100);
            case (phase)
                0: begin
                    lo_code = 0;
                    hi_code = 4095;
                    steps   = 1;
                end
                1: begin
                    lo_code = 4094;
                    hi_code = 4095;
                    steps   = 100;
                end
                4: begin
                    lo_code = 4095;
                    hi_code = 0;
                end
                5: begin
                    steps = $urandom_range(101, 127);
                    words = 8;
                end
                default: ;
            endcase
            set_taper(lo_code, hi_code, steps);
            // One phase runs back to back, with no sender gaps and no random receiver stalls.
            gaps_on = (phase != 3);
            for (int i = 0; i < words; i++) begin
                send_random_word();
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls, long hold-offs on request, and the result check.
    initial begin : result_sink
        int stall_left;
        t_taper_result want;
        stall_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with none expected (raw %0d, level %0d)",
                             $time, o_raw_code_out, o_ui_level_out);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_raw_code_out !== want.raw_code) begin
                        $display("%0t: raw_code_out expected %0d, got %0d",
                                 $time, want.raw_code, o_raw_code_out);
                        fail_count++;
                    end
                    if (o_ui_level_out !== want.ui_level) begin
                        $display("%0t: ui_level_out expected %0d, got %0d",
                                 $time, want.ui_level, o_ui_level_out);
                        fail_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = stall_length();
            end
            i_out_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // Main sequence.
    initial begin : test_sequence
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= cbtm_pkg::CMD_FORWARD;
        i_ui_level_in <= '0;
        i_raw_code_in <= '0;
        cfg_raw_min = 0;
        cfg_raw_max = 4095;
        cfg_ui_max  = cbtm_pkg::UI_MAX_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_taper();
        test_degenerate_settings();
        test_backpressure();
        test_random_settings();
        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #100_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
